@@ rtl/core/glsr_pkg.sv @@
// Shared types and constants for the graph link store.
`timescale 1ns / 1ps

package glsr_pkg;

  // Field widths of the channel words
  localparam int NODE_W = 5;
  localparam int FUNC_W = 2;
  localparam int CFG_W  = 6;
  // Node count after saturation fits in one more bit than the register
  localparam int CNT_W  = 7;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_CONNECT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REACH   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DIRECT  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd3;

  // Command group from the controller to the link store
  typedef struct packed {
    logic clear;
    logic rd;
    logic wr;
  } adj_cmd_t;

endpackage

@@ rtl/core/glsr_in_if.sv @@
// Request channel: valid/ready handshake carrying one operation word.
`timescale 1ns / 1ps

interface glsr_in_if
  import glsr_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [NODE_W-1:0] node_a;
  logic [NODE_W-1:0] node_b;
  logic              pair_allowed;

  modport source (output valid, func, node_a, node_b, pair_allowed, input ready);
  modport sink   (input valid, func, node_a, node_b, pair_allowed, output ready);
endinterface

@@ rtl/core/glsr_out_if.sv @@
// Result channel: valid/ready handshake carrying one result word.
`timescale 1ns / 1ps

interface glsr_out_if;
  logic valid;
  logic ready;
  logic answer;
  logic link_added;

  modport source (output valid, answer, link_added, input ready);
  modport sink   (input valid, answer, link_added, output ready);
endinterface

@@ rtl/core/glsr_adj_store.sv @@
// Adjacency row memory with per-row valid bits, so clear needs no pass over the rows.
`timescale 1ns / 1ps

module glsr_adj_store
  import glsr_pkg::*;
#(
  parameter int ROWS = 32,
  parameter int AW   = 5
) (
  input  logic            clk,
  input  logic            rst_n,
  input  adj_cmd_t        cmd,
  input  logic [AW-1:0]   rd_addr,
  input  logic [AW-1:0]   wr_addr,
  input  logic [ROWS-1:0] wr_row,
  output logic [ROWS-1:0] rd_row
);

  logic [ROWS-1:0] mem [ROWS];
  logic [ROWS-1:0] rd_q_r;
  logic            rd_vld_r;
  logic            rd_vld_nxt;
  logic [ROWS-1:0] valid_r;
  logic [ROWS-1:0] valid_nxt;

  // Row storage: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[wr_addr] <= wr_row;
    end
    if (cmd.rd) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // Valid bits: a row never written since clear reads as zero
  always_comb begin
    valid_nxt = valid_r;
    if (cmd.clear) begin
      valid_nxt = '0;
    end else if (cmd.wr) begin
      valid_nxt[wr_addr] = 1'b1;
    end
    rd_vld_nxt = rd_vld_r;
    if (cmd.rd) begin
      rd_vld_nxt = valid_r[rd_addr] & ~cmd.clear;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      valid_r  <= valid_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  assign rd_row = rd_vld_r ? rd_q_r : '0;

endmodule

@@ rtl/core/graph_link_store_with_reachability.sv @@
// Top level: undirected link store with connect, reachability and link queries.
`timescale 1ns / 1ps

// Holds a symmetric adjacency matrix, one row per node in a synchronous memory
// with a registered read. A word is taken only when the controller is idle.
// Clear and a direct-link query go from S_ROWA to S_DONE, where the result
// register loads once the output is free. A connect or reachability query reads
// the row of node_a, then walks the graph one adjacency row per cycle; a
// connect that adds a link writes row a and reads row b, then writes row b in
// S_ROWB. The controller returns to idle as the result register loads, and a
// result waiting for the receiver holds off the input. Clear empties the matrix
// through per-row valid bits, so there is no clearing pass after reset.
// node_count values above MAX_NODES act as MAX_NODES.

module graph_link_store_with_reachability
  import glsr_pkg::*;
#(
  parameter int MAX_NODES = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  glsr_in_if.sink          in_ch,
  glsr_out_if.source       out_ch
);

  localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ROWA = 3'd1;
  localparam logic [2:0] S_WALK = 3'd2;
  localparam logic [2:0] S_ROWB = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]           state_r, state_nxt;
  logic [CFG_W-1:0]     node_count_r;
  logic [FUNC_W-1:0]    func_r, func_nxt;
  logic [NODE_W-1:0]    a_r, a_nxt;
  logic [NODE_W-1:0]    b_r, b_nxt;
  logic                 allowed_r, allowed_nxt;
  logic [MAX_NODES-1:0] rowa_r, rowa_nxt;
  logic [MAX_NODES-1:0] vis_r, vis_nxt;
  logic [MAX_NODES-1:0] pend_r, pend_nxt;
  logic                 ans_r, ans_nxt;
  logic                 add_r, add_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_ans_r, out_ans_nxt;
  logic                 out_add_r, out_add_nxt;

  logic [CNT_W-1:0]     n_eff;
  logic [MAX_NODES-1:0] lim;
  logic                 in_range;
  logic [NW-1:0]        a_idx, b_idx;
  logic [MAX_NODES-1:0] a_oh, b_oh;
  logic [MAX_NODES-1:0] row;
  logic [MAX_NODES-1:0] vis_base, pend_base, fresh, pend_all, pend_rest;
  logic [MAX_NODES-1:0] rowa_eff;
  logic [NW-1:0]        pick;
  logic                 found;
  logic                 pair_ok;
  logic                 accept;
  logic                 out_free;

  adj_cmd_t             cmd;
  logic [NW-1:0]        rd_addr, wr_addr;
  logic [MAX_NODES-1:0] wr_row;

  // Lowest set bit of a node set
  function automatic logic [NW-1:0] lowest(input logic [MAX_NODES-1:0] v);
    logic [NW-1:0] idx;
    idx = '0;
    for (int i = MAX_NODES - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = NW'(i);
      end
    end
    return idx;
  endfunction

  glsr_adj_store #(
    .ROWS (MAX_NODES),
    .AW   (NW)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_row  (wr_row),
    .rd_row  (row)
  );

  // Active node count and mask of nodes in use
  always_comb begin
    n_eff = (CNT_W'(node_count_r) > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                       : CNT_W'(node_count_r);
    for (int i = 0; i < MAX_NODES; i++) begin
      lim[i] = (CNT_W'(i) < n_eff);
    end
  end

  assign a_idx    = NW'(a_r);
  assign b_idx    = NW'(b_r);
  assign a_oh     = MAX_NODES'(1) << a_idx;
  assign b_oh     = MAX_NODES'(1) << b_idx;
  assign in_range = (CNT_W'(a_r) < n_eff) && (CNT_W'(b_r) < n_eff);
  assign pair_ok  = in_range && (a_r != b_r) &&
                    ((func_r != FUNC_CONNECT) || allowed_r);

  // One walk step: expand the row just read
  assign vis_base  = (state_r == S_ROWA) ? a_oh : vis_r;
  assign pend_base = (state_r == S_ROWA) ? '0 : pend_r;
  assign fresh     = row & lim & ~vis_base;
  assign found     = fresh[b_idx];
  assign pend_all  = pend_base | fresh;
  assign pend_rest = pend_all & (pend_all - MAX_NODES'(1));
  assign pick      = lowest(pend_all);
  assign rowa_eff  = (state_r == S_ROWA) ? row : rowa_r;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // Controller
  always_comb begin
    state_nxt   = state_r;
    func_nxt    = func_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    allowed_nxt = allowed_r;
    rowa_nxt    = rowa_r;
    vis_nxt     = vis_r;
    pend_nxt    = pend_r;
    ans_nxt     = ans_r;
    add_nxt     = add_r;
    cmd         = '0;
    rd_addr     = pick;
    wr_addr     = a_idx;
    wr_row      = rowa_eff | b_oh;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          func_nxt    = in_ch.func;
          a_nxt       = in_ch.node_a;
          b_nxt       = in_ch.node_b;
          allowed_nxt = in_ch.pair_allowed;
          cmd.rd      = 1'b1;
          rd_addr     = NW'(in_ch.node_a);
          cmd.clear   = (in_ch.func == FUNC_CLEAR);
          state_nxt   = S_ROWA;
        end
      end

      S_ROWA, S_WALK: begin
        ans_nxt  = 1'b0;
        add_nxt  = 1'b0;
        rowa_nxt = rowa_eff;
        if (func_r == FUNC_CLEAR) begin
          state_nxt = S_DONE;
        end else if (func_r == FUNC_DIRECT) begin
          ans_nxt   = in_range && row[b_idx];
          state_nxt = S_DONE;
        end else if ((state_r == S_ROWA) && !pair_ok) begin
          state_nxt = S_DONE;
        end else if (found) begin
          ans_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else if (pend_all == '0) begin
          // Not reachable: a connect links the pair, row a first
          if (func_r == FUNC_CONNECT) begin
            cmd.wr    = 1'b1;
            cmd.rd    = 1'b1;
            rd_addr   = b_idx;
            state_nxt = S_ROWB;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          cmd.rd    = 1'b1;
          vis_nxt   = vis_base | fresh;
          pend_nxt  = pend_rest;
          state_nxt = S_WALK;
        end
      end

      S_ROWB: begin
        cmd.wr    = 1'b1;
        wr_addr   = b_idx;
        wr_row    = row | a_oh;
        ans_nxt   = 1'b1;
        add_nxt   = 1'b1;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output word register
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_ans_nxt   = out_ans_r;
    out_add_nxt   = out_add_r;
    if ((state_r == S_DONE) && out_free) begin
      out_valid_nxt = 1'b1;
      out_ans_nxt   = ans_r;
      out_add_nxt   = add_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.answer     = out_ans_r;
  assign out_ch.link_added = out_add_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      node_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        node_count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    func_r    <= func_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    allowed_r <= allowed_nxt;
    rowa_r    <= rowa_nxt;
    vis_r     <= vis_nxt;
    pend_r    <= pend_nxt;
    ans_r     <= ans_nxt;
    add_r     <= add_nxt;
    out_ans_r <= out_ans_nxt;
    out_add_r <= out_add_nxt;
  end

endmodule

@@ sim/graph_link_store_with_reachability_tb.sv @@
// Self-checking testbench for the graph link store: random and directed words, scoreboard check.
`timescale 1ns / 1ps

module graph_link_store_with_reachability_tb;
  import glsr_pkg::*;

  localparam int NODES        = 32;
  // Slowest legal run is about 1700 words, each at its longest gap, stall and walk,
  // plus two hold-offs; the limit allows several times that.
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int PHASE_WORDS  = 165;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic              pair_allowed;
  } link_request_t;

  typedef struct packed {
    logic answer;
    logic link_added;
  } link_result_t;

  // Scoreboard: mirrors the link matrix and holds expected results in order
  class link_store_scoreboard;
    logic [NODES-1:0] links [NODES];
    logic [CFG_W-1:0] node_count;
    link_result_t     expected_results [$];
    int               failures;

    function new();
      foreach (links[i]) links[i] = '0;
      node_count = '0;
      failures   = 0;
    endfunction

    function int unsigned active_nodes();
      return (node_count > NODES) ? NODES : node_count;
    endfunction

    function void set_node_count(logic [CFG_W-1:0] value);
      node_count = value;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Set of nodes connected to start, using only nodes below the active count
    function logic [NODES-1:0] component_of(logic [NODE_W-1:0] start);
      logic [NODES-1:0] lim;
      logic [NODES-1:0] seen;
      logic [NODES-1:0] grown;
      int unsigned      n;
      n     = active_nodes();
      lim   = (n >= NODES) ? '1 : ((NODES'(1) << n) - 1'b1);
      grown = NODES'(1) << start;
      do begin
        seen = grown;
        for (int i = 0; i < NODES; i++)
          if (seen[i]) grown |= links[i] & lim;
      end while (grown != seen);
      return seen;
    endfunction

    // Apply one accepted request word and queue its result
    function void note_word(link_request_t w);
      int unsigned      n;
      logic             in_range;
      logic [NODES-1:0] reach;
      link_result_t     r;
      n        = active_nodes();
      in_range = (w.node_a < n) && (w.node_b < n);
      r        = '0;
      case (w.func)
        FUNC_CONNECT: begin
          if (in_range && w.node_a != w.node_b && w.pair_allowed) begin
            reach    = component_of(w.node_a);
            r.answer = 1'b1;
            if (!reach[w.node_b]) begin
              links[w.node_a][w.node_b] = 1'b1;
              links[w.node_b][w.node_a] = 1'b1;
              r.link_added = 1'b1;
            end
          end
        end
        FUNC_REACH: begin
          if (in_range && w.node_a != w.node_b) begin
            reach    = component_of(w.node_a);
            r.answer = reach[w.node_b];
          end
        end
        FUNC_DIRECT: begin
          if (in_range) r.answer = links[w.node_a][w.node_b];
        end
        default: begin
          foreach (links[i]) links[i] = '0;
        end
      endcase
      expected_results.push_back(r);
    endfunction

    // Compare one accepted result word with the oldest expectation
    function void check_word(logic answer, logic link_added);
      link_result_t exp_r;
      if (expected_results.size() == 0) begin
        $error("result word with no request pending: answer %0b link_added %0b",
               answer, link_added);
        failures++;
        return;
      end
      exp_r = expected_results.pop_front();
      if (answer !== exp_r.answer) begin
        $error("answer: expected %0b, got %0b", exp_r.answer, answer);
        failures++;
      end
      if (link_added !== exp_r.link_added) begin
        $error("link_added: expected %0b, got %0b", exp_r.link_added, link_added);
        failures++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  logic             calm;
  int               words_sent;

  glsr_in_if  in_ch ();
  glsr_out_if out_ch ();

  link_store_scoreboard board;

  graph_link_store_with_reachability #(
    .MAX_NODES (NODES)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("[graph_link_store_with_reachability] ERROR");
    $finish;
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Mostly nodes in range, some anywhere in the field
  function automatic logic [NODE_W-1:0] pick_node(int unsigned n);
    if (n > 0 && $urandom_range(0, 9) < 8) return NODE_W'($urandom_range(0, n - 1));
    return NODE_W'($urandom_range(0, NODES - 1));
  endfunction

  // Offer one request word and wait for it to be taken
  task automatic send_word(logic [FUNC_W-1:0] func, logic [NODE_W-1:0] a,
                           logic [NODE_W-1:0] b, logic allowed);
    link_request_t w;
    int            gap;
    w   = '{func: func, node_a: a, node_b: b, pair_allowed: allowed};
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.func         <= w.func;
    in_ch.node_a       <= w.node_a;
    in_ch.node_b       <= w.node_b;
    in_ch.pair_allowed <= w.pair_allowed;
    do @(posedge clk); while (!in_ch.ready);
    board.note_word(w);
    words_sent++;
  endtask

  // Let every result drain, then let the controller settle back to idle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_node_count(logic [CFG_W-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    board.set_node_count(value);
  endtask

  // Result side: random stalls, plus two long hold-offs to back up the block
  initial begin
    int stall_left;
    int hold_left;
    int taken;
    stall_left = 0;
    hold_left  = 0;
    taken      = 0;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        board.check_word(out_ch.answer, out_ch.link_added);
        taken++;
        if (taken == 300 || taken == 1100) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Stimulus
  initial begin
    logic [CFG_W-1:0]  plan [10];
    logic [NODE_W-1:0] order [NODES];
    logic [NODE_W-1:0] t;
    logic [FUNC_W-1:0] f;
    int unsigned       n;
    int                phase_end;
    int                len;
    int                j;
    int                r;

    board      = new();
    calm       = 1'b0;
    words_sent = 0;
    plan       = '{6'd32, 6'd1, 6'd63, 6'd5, 6'd0, 6'd17, 6'd2, 6'd33, 6'd12, 6'd32};

    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.func         <= FUNC_CONNECT;
    in_ch.node_a       <= '0;
    in_ch.node_b       <= '0;
    in_ch.pair_allowed <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: node count zero after reset, every pair invalid
    send_word(FUNC_CONNECT, 5'd0, 5'd1, 1'b1);
    send_word(FUNC_REACH, 5'd0, 5'd1, 1'b1);

    // Full node range: link, already reachable, equal nodes, refused pair, walk
    write_node_count(6'd32);
    send_word(FUNC_REACH, 5'd0, 5'd31, 1'b0);
    send_word(FUNC_CONNECT, 5'd0, 5'd31, 1'b1);
    send_word(FUNC_CONNECT, 5'd31, 5'd0, 1'b1);
    send_word(FUNC_DIRECT, 5'd31, 5'd0, 1'b0);
    send_word(FUNC_CONNECT, 5'd5, 5'd5, 1'b1);
    send_word(FUNC_CONNECT, 5'd3, 5'd4, 1'b0);
    send_word(FUNC_CONNECT, 5'd31, 5'd16, 1'b1);
    send_word(FUNC_REACH, 5'd0, 5'd16, 1'b1);
    send_word(FUNC_CONNECT, 5'd16, 5'd0, 1'b1);
    send_word(FUNC_REACH, 5'd4, 5'd4, 1'b1);
    send_word(FUNC_DIRECT, 5'd7, 5'd7, 1'b1);
    send_word(FUNC_CLEAR, 5'd31, 5'd31, 1'b1);
    send_word(FUNC_DIRECT, 5'd0, 5'd31, 1'b0);
    // Path 2 - 20 - 3 runs through a node that goes out of range below
    send_word(FUNC_CONNECT, 5'd2, 5'd20, 1'b1);
    send_word(FUNC_CONNECT, 5'd20, 5'd3, 1'b1);

    // Oversized count saturates
    write_node_count(6'd63);
    send_word(FUNC_REACH, 5'd2, 5'd3, 1'b0);

    // Small count: out-of-range pairs, walk masked at the active count
    write_node_count(6'd4);
    send_word(FUNC_CONNECT, 5'd2, 5'd9, 1'b1);
    send_word(FUNC_REACH, 5'd9, 5'd2, 1'b1);
    send_word(FUNC_DIRECT, 5'd2, 5'd20, 1'b0);
    send_word(FUNC_REACH, 5'd2, 5'd3, 1'b0);

    // Random phases over a plan of node counts
    foreach (plan[p]) begin
      write_node_count(plan[p]);
      calm      = ($urandom_range(0, 3) == 0);
      n         = board.active_nodes();
      phase_end = words_sent + PHASE_WORDS;
      while (words_sent < phase_end) begin
        if (n >= 2 && $urandom_range(0, 99) < 8) begin
          // Chain over a shuffled set of nodes: builds long walks
          for (int i = 0; i < NODES; i++) order[i] = NODE_W'(i);
          for (int i = n - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            t        = order[i];
            order[i] = order[j];
            order[j] = t;
          end
          len = $urandom_range(2, n);
          if ($urandom_range(0, 2) == 0)
            send_word(FUNC_CLEAR, pick_node(n), pick_node(n), 1'($urandom_range(0, 1)));
          for (int i = 0; i + 1 < len; i++)
            send_word(FUNC_CONNECT, order[i], order[i + 1], 1'b1);
          send_word(FUNC_REACH, order[0], order[len - 1], 1'($urandom_range(0, 1)));
          send_word(FUNC_CONNECT, order[len - 1], order[0], 1'b1);
          send_word(FUNC_DIRECT, order[$urandom_range(0, len - 1)],
                    order[$urandom_range(0, len - 1)], 1'($urandom_range(0, 1)));
        end else begin
          r = $urandom_range(0, 99);
          if (r < 40)      f = FUNC_CONNECT;
          else if (r < 70) f = FUNC_REACH;
          else if (r < 97) f = FUNC_DIRECT;
          else             f = FUNC_CLEAR;
          send_word(f, pick_node(n), pick_node(n), ($urandom_range(0, 9) < 8));
        end
      end
    end

    // Wind down
    calm = 1'b0;
    drain();
    repeat (40) @(posedge clk);
    if (board.failures == 0 && board.pending() == 0) begin
      $display("[graph_link_store_with_reachability] OK");
    end else begin
      $display("[graph_link_store_with_reachability] ERROR");
    end
    $finish;
  end

endmodule
